// ===== sv/lc3s_pkg.sv =====
// Shared types, codes and field helpers for the LC-3 instruction step core.
`default_nettype none

package lc3s_pkg;

   // Request codes on req_type
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_EXEC  = 2'd1;
   localparam logic [1:0] REQ_SETPC = 2'd2;

   // Opcodes, instruction bits 15:12
   localparam logic [3:0] OP_BR   = 4'h0;
   localparam logic [3:0] OP_ADD  = 4'h1;
   localparam logic [3:0] OP_LD   = 4'h2;
   localparam logic [3:0] OP_ST   = 4'h3;
   localparam logic [3:0] OP_JSR  = 4'h4;
   localparam logic [3:0] OP_AND  = 4'h5;
   localparam logic [3:0] OP_LDR  = 4'h6;
   localparam logic [3:0] OP_STR  = 4'h7;
   localparam logic [3:0] OP_RTI  = 4'h8;
   localparam logic [3:0] OP_NOT  = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_STI  = 4'hB;
   localparam logic [3:0] OP_JMP  = 4'hC;
   localparam logic [3:0] OP_RSV  = 4'hD;
   localparam logic [3:0] OP_LEA  = 4'hE;
   localparam logic [3:0] OP_TRAP = 4'hF;

   // Condition flags, N Z P
   localparam logic [2:0] FLAG_N = 3'b100;
   localparam logic [2:0] FLAG_Z = 3'b010;
   localparam logic [2:0] FLAG_P = 3'b001;

   localparam logic [2:0] LINK_REG = 3'd7;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_FETCH,
      ST_DECODE,
      ST_LOAD
   } state_type;

   // Outcome of the execute stage
   typedef struct packed {
      logic [15:0] npc;
      logic        rw;
      logic [2:0]  ridx;
      logic [15:0] rval;
      logic        setcc;
      logic        mw;
      logic [15:0] maddr;
      logic [15:0] mval;
      logic        need_load;
      logic [15:0] laddr;
   } exec_type;

   // PC-relative address from the 9-bit offset
   function automatic logic [15:0] pc_off9(input logic [15:0] pc1, input logic [15:0] ir);
      return pc1 + {{7{ir[8]}}, ir[8:0]};
   endfunction

   // Stores read the source register from the DR field, others from SR2
   function automatic logic [2:0] second_reg(input logic [15:0] ir);
      logic [3:0] op;
      op = ir[15:12];
      if (op == OP_ST || op == OP_STI || op == OP_STR) begin
         return ir[11:9];
      end
      return ir[2:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/lc3s_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none

module lc3s_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and hold read data until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/lc3s_wrap.sv =====
// Reduce a 16-bit address modulo the memory size.
`default_nettype none

module lc3s_wrap #(
   parameter int MEM_WORDS = 32768
) (
   input  wire logic [15:0]                  addr,
   output logic      [$clog2(MEM_WORDS)-1:0] wrapped
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [AW:0] MEM_SIZE = (AW+1)'(MEM_WORDS);

   logic [AW-1:0] hi_tbl [256];
   logic [AW:0]   sum;

   // Constant table: (high byte * 256) mod size
   for (genvar g = 0; g < 256; g++) begin : gen_hi
      localparam int unsigned HI_MOD = (g * 256) % MEM_WORDS;
      assign hi_tbl[g] = AW'(HI_MOD);
   end

   // Low byte adds less than the size, so one subtract corrects the sum
   always_comb begin
      sum = {1'b0, hi_tbl[addr[15:8]]} + (AW+1)'(addr[7:0]);
      if (sum >= MEM_SIZE) begin
         sum = sum - MEM_SIZE;
      end
   end

   assign wrapped = sum[AW-1:0];

endmodule

`default_nettype wire

// ===== sv/lc3s_exec.sv =====
// Execute stage: operates on the fetched instruction and its operands.
`default_nettype none

module lc3s_exec
   import lc3s_pkg::*;
(
   input  wire logic [15:0] ir,
   input  wire logic [15:0] pc,
   input  wire logic [2:0]  flags,
   input  wire logic [15:0] opa,
   input  wire logic [15:0] opb,
   input  wire logic [15:0] ld_data,
   output exec_type         ex
);

   logic [15:0] pc1;
   logic [15:0] off9;
   logic [15:0] base6;
   logic [15:0] imm5;
   logic [15:0] alu_b;

   assign pc1   = pc + 16'd1;
   assign off9  = pc_off9(pc1, ir);
   assign base6 = opa + {{10{ir[5]}}, ir[5:0]};
   assign imm5  = {{11{ir[4]}}, ir[4:0]};
   assign alu_b = ir[5] ? imm5 : opb;

   // Decode the opcode into register, flag, memory and PC effects
   always_comb begin
      ex           = '0;
      ex.npc       = pc1;
      unique case (ir[15:12])
         OP_ADD: begin
            ex.rw = 1'b1; ex.ridx = ir[11:9]; ex.rval = opa + alu_b; ex.setcc = 1'b1;
         end
         OP_AND: begin
            ex.rw = 1'b1; ex.ridx = ir[11:9]; ex.rval = opa & alu_b; ex.setcc = 1'b1;
         end
         OP_NOT: begin
            ex.rw = 1'b1; ex.ridx = ir[11:9]; ex.rval = ~opa; ex.setcc = 1'b1;
         end
         OP_BR: begin
            if ((ir[11:9] & flags) != 3'b000) begin
               ex.npc = off9;
            end
         end
         OP_JMP: begin
            ex.npc = opa;
         end
         OP_JSR: begin
            ex.npc  = ir[11] ? (pc1 + {{5{ir[10]}}, ir[10:0]}) : opa;
            ex.rw   = 1'b1;
            ex.ridx = LINK_REG;
            ex.rval = pc1;
         end
         OP_LD: begin
            ex.rw = 1'b1; ex.ridx = ir[11:9]; ex.rval = ld_data; ex.setcc = 1'b1;
         end
         OP_LDI: begin
            ex.need_load = 1'b1;
            ex.laddr     = ld_data;
         end
         OP_LDR: begin
            ex.need_load = 1'b1;
            ex.laddr     = base6;
         end
         OP_LEA: begin
            ex.rw = 1'b1; ex.ridx = ir[11:9]; ex.rval = off9;
         end
         OP_ST: begin
            ex.mw = 1'b1; ex.maddr = off9; ex.mval = opb;
         end
         OP_STI: begin
            ex.mw = 1'b1; ex.maddr = ld_data; ex.mval = opb;
         end
         OP_STR: begin
            ex.mw = 1'b1; ex.maddr = base6; ex.mval = opb;
         end
         OP_TRAP: begin
            ex.rw   = 1'b1;
            ex.ridx = LINK_REG;
            ex.rval = pc1;
            ex.npc  = 16'h0000;
         end
         OP_RTI, OP_RSV: begin
            ex.npc = pc;
         end
         default: begin
            ex.npc = pc;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/lc3_instruction_step_core.sv =====
// Top level of the LC-3 instruction step core: sequencer, state and result register.
`default_nettype none

// LC-3 core driven one word at a time: a request writes a memory word, loads
// the PC (clearing halt) or executes the instruction at the PC; each request
// returns one result word with the PC, flags, halt and any register or memory
// write. Main memory and both register file copies are synchronous RAMs with
// one read and one write port. A memory write, PC load or halting step ends
// in the start state; an instruction steps through fetch read, operand read
// and execute, and LDI and LDR add a load step, whose extra memory read goes
// through the same single read port. The next request is taken in the cycle
// the current one finishes, and while a result waits on rsp_ready. After
// reset the core zeroes all MEM_WORDS words of main memory (32768 by
// default), one word per cycle, with req_ready low.
module lc3_instruction_step_core
   import lc3s_pkg::*;
#(
   parameter int MEM_WORDS = 32768
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_target_addr,
   input  wire logic [15:0] req_word_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_next_pc,
   output logic [2:0]       rsp_flag_bits,
   output logic             rsp_halted,
   output logic             rsp_reg_written,
   output logic [2:0]       rsp_reg_index,
   output logic [15:0]      rsp_reg_value,
   output logic             rsp_mem_written,
   output logic [15:0]      rsp_mem_addr,
   output logic [15:0]      rsp_mem_value
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

   state_type   state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff;

   logic [15:0] pc_ff;
   logic [2:0]  flags_ff;
   logic        halt_ff;
   logic [7:0]  rf_vld_ff;

   logic [1:0]  req_type_ff;
   logic [15:0] req_addr_ff;
   logic [15:0] req_val_ff;
   logic [15:0] ir_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_next_pc_ff;
   logic [2:0]  rsp_flag_bits_ff;
   logic        rsp_halted_ff;
   logic        rsp_reg_written_ff;
   logic [2:0]  rsp_reg_index_ff;
   logic [15:0] rsp_reg_value_ff;
   logic        rsp_mem_written_ff;
   logic [15:0] rsp_mem_addr_ff;
   logic [15:0] rsp_mem_value_ff;

   logic        req_fire;
   logic        out_free;
   logic        fin;
   logic        done;
   logic        clr_en;

   logic        mem_rd_en;
   logic [15:0] rd_addr16;
   logic [AW-1:0] rd_wrapped;
   logic [15:0] mem_rdata;
   logic [15:0] wr_addr16;
   logic [AW-1:0] wr_wrapped;
   logic [15:0] wr_val;
   logic        mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0] mem_wdata;

   logic        rf_rd_en;
   logic [2:0]  ra_idx;
   logic [2:0]  rb_idx;
   logic [15:0] rf_a_rdata;
   logic [15:0] rf_b_rdata;
   logic [15:0] opa;
   logic [15:0] opb;

   logic [15:0] npc;
   logic [2:0]  flags_new;
   logic        halt_new;
   logic        rw;
   logic [2:0]  ridx;
   logic [15:0] rval;
   logic        mw;

   exec_type    ex;

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      if (v == 16'h0000) begin
         return FLAG_Z;
      end
      return v[15] ? FLAG_N : FLAG_P;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || done;
   assign req_fire  = req_valid && req_ready;

   // Address reduction for the read and write ports
   lc3s_wrap #(.MEM_WORDS(MEM_WORDS)) u_rd_wrap (.addr(rd_addr16), .wrapped(rd_wrapped));
   lc3s_wrap #(.MEM_WORDS(MEM_WORDS)) u_wr_wrap (.addr(wr_addr16), .wrapped(wr_wrapped));

   // Main memory
   assign mem_we    = clr_en || (done && mw);
   assign mem_waddr = clr_en ? clr_cnt_ff : wr_wrapped;
   assign mem_wdata = clr_en ? 16'h0000 : wr_val;

   lc3s_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_main_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_wrapped),
      .rd_data (mem_rdata)
   );

   // Register file: two copies give two reads per cycle
   assign ra_idx = mem_rdata[8:6];
   assign rb_idx = second_reg(mem_rdata);

   lc3s_ram #(.WIDTH(16), .DEPTH(8)) u_rf_a (
      .clock   (clock),
      .wr_en   (done && rw),
      .wr_addr (ridx),
      .wr_data (rval),
      .rd_en   (rf_rd_en),
      .rd_addr (ra_idx),
      .rd_data (rf_a_rdata)
   );

   lc3s_ram #(.WIDTH(16), .DEPTH(8)) u_rf_b (
      .clock   (clock),
      .wr_en   (done && rw),
      .wr_addr (ridx),
      .wr_data (rval),
      .rd_en   (rf_rd_en),
      .rd_addr (rb_idx),
      .rd_data (rf_b_rdata)
   );

   // Registers never written since reset read as zero
   assign opa = rf_vld_ff[ir_ff[8:6]] ? rf_a_rdata : 16'h0000;
   assign opb = rf_vld_ff[second_reg(ir_ff)] ? rf_b_rdata : 16'h0000;

   lc3s_exec u_exec (
      .ir      (ir_ff),
      .pc      (pc_ff),
      .flags   (flags_ff),
      .opa     (opa),
      .opb     (opb),
      .ld_data (mem_rdata),
      .ex      (ex)
   );

   // Sequencer: next state, memory requests and the item outcome
   always_comb begin
      state_in  = state_ff;
      fin       = 1'b0;
      clr_en    = 1'b0;
      mem_rd_en = 1'b0;
      rd_addr16 = pc_ff;
      rf_rd_en  = 1'b0;
      wr_addr16 = 16'h0000;
      wr_val    = 16'h0000;
      npc       = pc_ff;
      flags_new = flags_ff;
      halt_new  = halt_ff;
      rw        = 1'b0;
      ridx      = 3'd0;
      rval      = 16'h0000;
      mw        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_en = 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // req_ready is high here, so a valid word is taken
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            unique case (req_type_ff)
               REQ_WRITE: begin
                  fin       = 1'b1;
                  mw        = 1'b1;
                  wr_addr16 = req_addr_ff;
                  wr_val    = req_val_ff;
               end
               REQ_SETPC: begin
                  fin      = 1'b1;
                  npc      = req_val_ff;
                  halt_new = 1'b0;
               end
               REQ_EXEC: begin
                  if (pc_ff == 16'h0000) begin
                     fin      = 1'b1;
                     halt_new = 1'b1;
                  end else begin
                     mem_rd_en = 1'b1;
                     rd_addr16 = pc_ff;
                     state_in  = ST_FETCH;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         ST_FETCH: begin
            // Instruction is on the read port: fetch operands
            mem_rd_en = 1'b1;
            rd_addr16 = pc_off9(pc_ff + 16'd1, mem_rdata);
            rf_rd_en  = 1'b1;
            state_in  = ST_DECODE;
         end
         ST_DECODE: begin
            if (ex.need_load) begin
               mem_rd_en = 1'b1;
               rd_addr16 = ex.laddr;
               state_in  = ST_LOAD;
            end else begin
               fin       = 1'b1;
               npc       = ex.npc;
               rw        = ex.rw;
               ridx      = ex.ridx;
               rval      = ex.rval;
               mw        = ex.mw;
               wr_addr16 = ex.maddr;
               wr_val    = ex.mval;
               if (ex.setcc) begin
                  flags_new = flags_of(ex.rval);
               end
            end
         end
         ST_LOAD: begin
            fin       = 1'b1;
            npc       = pc_ff + 16'd1;
            rw        = 1'b1;
            ridx      = ir_ff[11:9];
            rval      = mem_rdata;
            flags_new = flags_of(mem_rdata);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // req_ready follows done, so a valid word is taken as this one ends
      done = fin && out_free;
      if (done) begin
         state_in = req_valid ? ST_START : ST_IDLE;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         pc_ff        <= 16'h0000;
         flags_ff     <= FLAG_Z;
         halt_ff      <= 1'b0;
         rf_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clr_en) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (done) begin
            pc_ff    <= npc;
            flags_ff <= flags_new;
            halt_ff  <= halt_new;
            if (rw) begin
               rf_vld_ff[ridx] <= 1'b1;
            end
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture, instruction hold and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_type_ff <= req_type;
         req_addr_ff <= req_target_addr;
         req_val_ff  <= req_word_value;
      end
      if (state_ff == ST_FETCH) begin
         ir_ff <= mem_rdata;
      end
      if (done) begin
         rsp_next_pc_ff     <= npc;
         rsp_flag_bits_ff   <= flags_new;
         rsp_halted_ff      <= halt_new;
         rsp_reg_written_ff <= rw;
         rsp_reg_index_ff   <= ridx;
         rsp_reg_value_ff   <= rval;
         rsp_mem_written_ff <= mw;
         rsp_mem_addr_ff    <= mw ? 16'(wr_wrapped) : 16'h0000;
         rsp_mem_value_ff   <= wr_val;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_flag_bits   = rsp_flag_bits_ff;
   assign rsp_halted      = rsp_halted_ff;
   assign rsp_reg_written = rsp_reg_written_ff;
   assign rsp_reg_index   = rsp_reg_index_ff;
   assign rsp_reg_value   = rsp_reg_value_ff;
   assign rsp_mem_written = rsp_mem_written_ff;
   assign rsp_mem_addr    = rsp_mem_addr_ff;
   assign rsp_mem_value   = rsp_mem_value_ff;

endmodule

`default_nettype wire

// ===== sv/lc3s_chk.sv =====
// Port-level checker for the LC-3 instruction step core, bound to the top level.
`default_nettype none

module lc3s_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_type,
   input wire logic [15:0] req_target_addr,
   input wire logic [15:0] req_word_value,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_next_pc,
   input wire logic [2:0]  rsp_flag_bits,
   input wire logic        rsp_halted,
   input wire logic        rsp_reg_written,
   input wire logic [2:0]  rsp_reg_index,
   input wire logic [15:0] rsp_reg_value,
   input wire logic        rsp_mem_written,
   input wire logic [15:0] rsp_mem_addr,
   input wire logic [15:0] rsp_mem_value
);

   // Hold a waiting request word
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_type)
         && $stable(req_target_addr) && $stable(req_word_value))
      else $error("request word changed while waiting");

   // Hold a stalled result: valid, next PC, register value and memory value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc)
         && $stable(rsp_reg_value) && $stable(rsp_mem_value))
      else $error("result word changed while stalled");

   // Exactly one condition flag is set in every result
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_flag_bits))
      else $error("condition flags not one-hot");

   // A halted core sits at PC zero
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |-> rsp_next_pc == 16'h0000)
      else $error("halted with nonzero PC");

   // No item writes both a register and memory; idle write fields are zero
   a_write_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_reg_written && rsp_mem_written)
         && (rsp_reg_written || (rsp_reg_index == 3'd0 && rsp_reg_value == 16'h0000))
         && (rsp_mem_written || (rsp_mem_addr == 16'h0000 && rsp_mem_value == 16'h0000)))
      else $error("inconsistent write report");

endmodule

bind lc3_instruction_step_core lc3s_chk u_lc3s_chk (.*);

`default_nettype wire

// ===== dv/tb_lc3_instruction_step_core.sv =====
// Testbench for the LC-3 step core: directed and random programs checked against a local model.
`timescale 1ns / 1ps

module tb_lc3_instruction_step_core
   import lc3s_pkg::*;
();

   localparam int MEM_WORDS   = 32768;
   localparam int MEM_AW      = $clog2(MEM_WORDS);
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_WORDS = 1000;

   typedef struct packed {
      logic [15:0] next_pc;
      logic [2:0]  flag_bits;
      logic        halted;
      logic        reg_written;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic        mem_written;
      logic [15:0] mem_addr;
      logic [15:0] mem_value;
   } core_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_WRITE;
   logic [15:0] req_target_addr = '0;
   logic [15:0] req_word_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_next_pc;
   logic [2:0]  rsp_flag_bits;
   logic        rsp_halted;
   logic        rsp_reg_written;
   logic [2:0]  rsp_reg_index;
   logic [15:0] rsp_reg_value;
   logic        rsp_mem_written;
   logic [15:0] rsp_mem_addr;
   logic [15:0] rsp_mem_value;

   // Architectural state as this testbench sees it
   logic [15:0] mem_img [MEM_WORDS];
   logic [15:0] gpr [8];
   logic [15:0] pc_q;
   logic [2:0]  nzp_q;
   logic        halt_q;

   core_result_type pending_results [$];
   int  error_count = 0;
   int  results_seen = 0;
   int  words_sent = 0;
   int  cycle_count = 0;
   int  ready_hold = 0;
   bit  gaps_on = 1'b1;

   lc3_instruction_step_core #(.MEM_WORDS(MEM_WORDS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_target_addr (req_target_addr),
      .req_word_value  (req_word_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_flag_bits   (rsp_flag_bits),
      .rsp_halted      (rsp_halted),
      .rsp_reg_written (rsp_reg_written),
      .rsp_reg_index   (rsp_reg_index),
      .rsp_reg_value   (rsp_reg_value),
      .rsp_mem_written (rsp_mem_written),
      .rsp_mem_addr    (rsp_mem_addr),
      .rsp_mem_value   (rsp_mem_value)
   );

   always #6 clock = ~clock;

   // Fold an address into the memory
   function automatic logic [MEM_AW-1:0] mem_index(input logic [15:0] a);
      return MEM_AW'(a % MEM_WORDS);
   endfunction

   // Sign-extend the low bits of an instruction field
   function automatic logic [15:0] sext_field(input logic [15:0] ir, input int bits);
      logic [15:0] mask;
      logic [15:0] sign;
      mask = (16'h1 << bits) - 16'h1;
      sign = 16'h1 << (bits - 1);
      return ((ir & mask) ^ sign) - sign;
   endfunction

   function automatic logic [2:0] nzp_of(input logic [15:0] v);
      if (v == 16'h0) begin
         return FLAG_Z;
      end
      return v[15] ? FLAG_N : FLAG_P;
   endfunction

   // Mostly short gaps, a few long ones, none while gaps are off
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(11, 40);
   endfunction

   // Apply one request to the local state and work out the result word
   task automatic predict_step(input logic [1:0] kind, input logic [15:0] addr,
                               input logic [15:0] value, output core_result_type r);
      logic [15:0] ir;
      logic [15:0] pc1;
      logic [15:0] src_a;
      logic [15:0] opnd_b;
      logic [15:0] pcoff9;
      logic [15:0] baseoff6;
      logic [15:0] npc;
      logic [2:0]  dr;
      logic        setcc;
      r = '0;
      case (kind)
         REQ_WRITE: begin
            r.mem_written = 1'b1;
            r.mem_addr    = 16'(mem_index(addr));
            r.mem_value   = value;
            mem_img[mem_index(addr)] = value;
         end
         REQ_SETPC: begin
            pc_q   = value;
            halt_q = 1'b0;
         end
         REQ_EXEC: begin
            if (pc_q == 16'h0) begin
               halt_q = 1'b1;
            end else begin
               ir       = mem_img[mem_index(pc_q)];
               pc1      = pc_q + 16'd1;
               dr       = ir[11:9];
               src_a    = gpr[ir[8:6]];
               pcoff9   = pc1 + sext_field(ir, 9);
               baseoff6 = src_a + sext_field(ir, 6);
               npc      = pc1;
               setcc    = 1'b0;
               case (ir[15:12])
                  OP_ADD, OP_AND: begin
                     opnd_b = ir[5] ? sext_field(ir, 5) : gpr[ir[2:0]];
                     r.reg_value = (ir[15:12] == OP_ADD) ? src_a + opnd_b : src_a & opnd_b;
                     r.reg_written = 1'b1;
                     r.reg_index   = dr;
                     setcc = 1'b1;
                  end
                  OP_NOT: begin
                     r.reg_value   = ~src_a;
                     r.reg_written = 1'b1;
                     r.reg_index   = dr;
                     setcc = 1'b1;
                  end
                  OP_BR: begin
                     // the DR field holds the n z p condition bits here
                     if ((dr & nzp_q) != 3'b000) begin
                        npc = pcoff9;
                     end
                  end
                  OP_JMP: npc = src_a;
                  OP_JSR: begin
                     npc = ir[11] ? pc1 + sext_field(ir, 11) : src_a;
                     r.reg_written = 1'b1;
                     r.reg_index   = LINK_REG;
                     r.reg_value   = pc1;
                  end
                  OP_LD, OP_LDI, OP_LDR: begin
                     if (ir[15:12] == OP_LD) begin
                        r.reg_value = mem_img[mem_index(pcoff9)];
                     end else if (ir[15:12] == OP_LDI) begin
                        r.reg_value = mem_img[mem_index(mem_img[mem_index(pcoff9)])];
                     end else begin
                        r.reg_value = mem_img[mem_index(baseoff6)];
                     end
                     r.reg_written = 1'b1;
                     r.reg_index   = dr;
                     setcc = 1'b1;
                  end
                  OP_LEA: begin
                     r.reg_value   = pcoff9;
                     r.reg_written = 1'b1;
                     r.reg_index   = dr;
                  end
                  OP_ST, OP_STI, OP_STR: begin
                     if (ir[15:12] == OP_ST) begin
                        r.mem_addr = 16'(mem_index(pcoff9));
                     end else if (ir[15:12] == OP_STI) begin
                        r.mem_addr = 16'(mem_index(mem_img[mem_index(pcoff9)]));
                     end else begin
                        r.mem_addr = 16'(mem_index(baseoff6));
                     end
                     r.mem_value   = gpr[dr];
                     r.mem_written = 1'b1;
                  end
                  OP_TRAP: begin
                     r.reg_written = 1'b1;
                     r.reg_index   = LINK_REG;
                     r.reg_value   = pc1;
                     npc = 16'h0;
                  end
                  // RTI and the reserved opcode hold the PC
                  default: npc = pc_q;
               endcase
               if (r.reg_written) begin
                  gpr[r.reg_index] = r.reg_value;
               end
               if (setcc) begin
                  nzp_q = nzp_of(r.reg_value);
               end
               if (r.mem_written) begin
                  mem_img[MEM_AW'(r.mem_addr)] = r.mem_value;
               end
               pc_q = npc;
            end
         end
         default: ;
      endcase
      r.next_pc   = pc_q;
      r.flag_bits = nzp_q;
      r.halted    = halt_q;
   endtask

   // Offer one request word and hold it until the core takes it
   task automatic send_word(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [15:0] value);
      int gap;
      core_result_type want;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_target_addr <= addr;
      req_word_value  <= value;
      predict_step(kind, addr, value, want);
      pending_results.push_back(want);
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s got %h want %h",
                                   results_seen, name, got, want));
      end
   endtask

   // Random instruction, with PC-relative offsets kept near the PC most of the time
   function automatic logic [15:0] random_instruction();
      logic [15:0] ir;
      ir = 16'($urandom);
      if ($urandom_range(0, 2) != 0) begin
         case (ir[15:12])
            OP_BR, OP_LD, OP_ST, OP_LDI, OP_STI, OP_LEA:
               ir[8:0] = 9'($urandom_range(0, 16) - 8);
            OP_JSR:
               if (ir[11]) begin
                  ir[10:0] = 11'($urandom_range(0, 16) - 8);
               end
            default: ;
         endcase
      end
      return ir;
   endfunction

   // Execute at PC zero halts, halt holds, a PC load clears it
   task automatic test_halt_rules();
      send_word(REQ_EXEC, 16'hFFFF, 16'hFFFF);
      send_word(REQ_EXEC, 16'h0000, 16'h0000);
      send_word(REQ_SETPC, 16'h0000, 16'hFFFF);
   endtask

   // Addresses fold into memory; the wrapped word is fetched as a TRAP at PC FFFF
   task automatic test_memory_wrap();
      send_word(REQ_WRITE, 16'hFFFF, 16'hFFFF);
      send_word(REQ_WRITE, 16'h8000, 16'h5A5A);
      send_word(REQ_WRITE, 16'h0000, 16'h0000);
      send_word(REQ_EXEC, 16'h1234, 16'h0000);
      send_word(REQ_EXEC, 16'h0000, 16'h0000);
   endtask

   // Hand-built program near the top of the PC range for the corner instructions
   task automatic test_special_instructions();
      logic [15:0] prog [11];
      logic [15:0] base;
      base     = 16'hFFF0;
      prog[0]  = {OP_ADD, 3'd2, 3'd2, 1'b1, 5'h10};      // most negative immediate
      prog[1]  = {OP_ADD, 3'd1, 3'd2, 3'b011, 3'd2};     // register mode, bits 4:3 set
      prog[2]  = {OP_LEA, 3'd3, 9'h100};                 // flags must not move
      prog[3]  = {OP_BR, 3'b000, 9'h0FF};                // no conditions, falls through
      prog[4]  = {OP_JSR, 1'b1, 11'd1};
      prog[5]  = {OP_LDI, 3'd4, 9'h1FF};
      prog[6]  = {OP_JSR, 1'b0, 2'b00, 3'd7, 6'd0};      // JSRR through the link register
      prog[7]  = {OP_STI, 3'd1, 9'h1FE};
      prog[8]  = {OP_RTI, 12'h000};
      prog[9]  = {OP_RSV, 12'hFFF};
      prog[10] = {OP_TRAP, 4'h0, 8'h25};
      foreach (prog[i]) begin
         send_word(REQ_WRITE, base + 16'(i), prog[i]);
      end
      send_word(REQ_SETPC, 16'h0000, base);
      // walks 0 1 2 3 4 6 5 6 7 8
      repeat (10) send_word(REQ_EXEC, 16'h0000, 16'h0000);
      send_word(REQ_SETPC, 16'h0000, base + 16'd9);
      send_word(REQ_EXEC, 16'h0000, 16'h0000);
      send_word(REQ_SETPC, 16'h0000, base + 16'd10);
      repeat (3) send_word(REQ_EXEC, 16'h0000, 16'h0000);
   endtask

   // Load short random programs, point the PC at them and run; some noise in between
   task automatic test_random_programs();
      int start;
      int len;
      logic [15:0] base;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         gaps_on = ($urandom_range(0, 5) != 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(3, 8)) begin
               send_word(2'($urandom_range(0, 2)), 16'($urandom), 16'($urandom));
            end
         end else begin
            base = 16'($urandom);
            len  = $urandom_range(2, 12);
            repeat ($urandom_range(0, 3)) begin
               send_word(REQ_WRITE, base + 16'($urandom_range(0, 40)) - 16'd20,
                         16'($urandom));
            end
            for (int i = 0; i < len; i++) begin
               send_word(REQ_WRITE, base + 16'(i), random_instruction());
            end
            send_word(REQ_SETPC, 16'($urandom), base);
            repeat ($urandom_range(len, len + 6)) begin
               send_word(REQ_EXEC, 16'($urandom), 16'($urandom));
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // Result side: random stalls, some long, no new ones while gaps are off
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else if (!gaps_on) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 2) != 0) begin
         rsp_ready <= 1'b1;
         ready_hold = $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b0;
         ready_hold = idle_cycles();
      end
   end

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin : check_results
      core_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = pending_results.pop_front();
            check_field("next_pc", rsp_next_pc, want.next_pc);
            check_field("flag_bits", 16'(rsp_flag_bits), 16'(want.flag_bits));
            check_field("halted", 16'(rsp_halted), 16'(want.halted));
            check_field("reg_written", 16'(rsp_reg_written), 16'(want.reg_written));
            check_field("reg_index", 16'(rsp_reg_index), 16'(want.reg_index));
            check_field("reg_value", rsp_reg_value, want.reg_value);
            check_field("mem_written", 16'(rsp_mem_written), 16'(want.mem_written));
            check_field("mem_addr", rsp_mem_addr, want.mem_addr);
            check_field("mem_value", rsp_mem_value, want.mem_value);
         end
         results_seen++;
      end
   end

   // Drop the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lc3_instruction_step_core test failed");
         $finish;
      end
   end

   initial begin
      foreach (mem_img[i]) begin
         mem_img[i] = '0;
      end
      foreach (gpr[i]) begin
         gpr[i] = '0;
      end
      pc_q   = '0;
      nzp_q  = FLAG_Z;
      halt_q = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // the core clears its memory first; send_word waits on req_ready
      test_halt_rules();
      test_memory_wrap();
      test_special_instructions();
      test_random_programs();
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("lc3_instruction_step_core test passed");
      end else begin
         $display("lc3_instruction_step_core test failed");
      end
      $finish;
   end

endmodule
